>>> rtl/core/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and round functions for the AES-128 block pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

	// Field and block widths.
	localparam int unsigned HalfW     = 64;
	localparam int unsigned BlkW      = 2 * HalfW;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned CfgIdxW   = 1;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

	typedef logic [HalfW-1:0]   half_t;
	typedef logic [BlkW-1:0]    blk_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	typedef logic [7:0]         byte_t;
	typedef logic [31:0]        word_t;

	// Reduction polynomial for GF(2^8) doubling.
	localparam byte_t GF_POLY = 8'h1B;

	// Round constants, one per round, placed in the top byte of the word.
	localparam byte_t RCON [1:NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
	};

	// Forward substitution box.
	localparam byte_t SBOX [0:255] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic byte_t sbox(input byte_t b);
		return SBOX[b];
	endfunction

	// Multiply by two in GF(2^8).
	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	// Byte i of the state sits in bits 127-8i downto 120-8i (column-major order).
	function automatic byte_t get_byte(input blk_t s, input int unsigned i);
		return s[BlkW-1-8*i -: 8];
	endfunction

	// SubBytes followed by ShiftRows.
	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		t = '0;
		for (int unsigned c = 0; c < 4; c++) begin
			for (int unsigned r = 0; r < 4; r++) begin
				t[BlkW-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
			end
		end
		return t;
	endfunction

	// MixColumns on one column, row 0 in the top byte.
	function automatic word_t mix_column(input word_t col);
		byte_t a0, a1, a2, a3, d0, d1, d2, d3;
		a0 = col[31:24];
		a1 = col[23:16];
		a2 = col[15:8];
		a3 = col[7:0];
		d0 = xtime(a0);
		d1 = xtime(a1);
		d2 = xtime(a2);
		d3 = xtime(a3);
		return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
			a0 ^ d1 ^ d2 ^ a2 ^ a3,
			a0 ^ a1 ^ d2 ^ d3 ^ a3,
			d0 ^ a0 ^ a1 ^ a2 ^ d3};
	endfunction

	function automatic blk_t mix_columns(input blk_t s);
		blk_t t;
		t = '0;
		for (int unsigned c = 0; c < 4; c++) begin
			t[BlkW-1-32*c -: 32] = mix_column(s[BlkW-1-32*c -: 32]);
		end
		return t;
	endfunction

	// One step of the key schedule: four words of round key from the previous four.
	function automatic blk_t key_step(input blk_t k, input byte_t rc);
		word_t w0, w1, w2, w3, t, n0, n1, n2, n3;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t  = {w3[23:0], w3[31:24]};
		t  = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])} ^ {rc, 24'h000000};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

>>> rtl/core/aes_if.sv
// ----------------------------------------------------------------------------
// AES-128 channel interfaces
// Valid/ready channels for configuration writes, plaintext and ciphertext.
// ----------------------------------------------------------------------------

// Configuration write channel.
interface aes_cfg_if import aes_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	half_t    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// Plaintext block channel.
interface aes_blk_if import aes_pkg::*; ();
	logic  valid;
	logic  ready;
	half_t block_high;
	half_t block_low;

	modport source(output valid, block_high, block_low, input ready);
	modport sink(input valid, block_high, block_low, output ready);
endinterface

// Ciphertext block channel.
interface aes_ct_if import aes_pkg::*; ();
	logic  valid;
	logic  ready;
	half_t cipher_high;
	half_t cipher_low;

	modport source(output valid, cipher_high, cipher_low, input ready);
	modport sink(input valid, cipher_high, cipher_low, output ready);
endinterface

>>> rtl/core/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Encrypts 128-bit blocks under a 128-bit key held in two configuration
// registers, one round per pipeline stage.
// ----------------------------------------------------------------------------
// The block accepts one plaintext transaction every clock cycle unless the
// ciphertext channel stalls it, and returns the ciphertext in order: one
// stage performs the initial AddRoundKey, ten stages each perform one round
// together with the key schedule step for that round, and a two-entry output
// buffer holds results while the ciphertext channel stalls. Throughput is set
// by the round stages, each of which has its own S-boxes for the state and the
// key word. The key is written through the configuration channel (index 0
// holds key bytes 0 to 7, index 1 holds bytes 8 to 15) and applies to every
// block accepted after the write; both halves reset to zero.
module aes128_block_encrypt import aes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	aes_cfg_if.sink   cfg,
	aes_blk_if.sink   blk,
	aes_ct_if.source  ct
);

	half_t key_high_q;
	half_t key_low_q;
	logic  vld_s1;
	blk_t  state_s1;
	blk_t  rkey_s1;

	// Stage signals: index 0 is the AddRoundKey stage, index r the output of round r.
	logic  stg_vld [0:NumRounds];
	blk_t  stg_state [0:NumRounds];
	blk_t  stg_key [0:NumRounds];
	logic  stg_rdy [1:NumRounds+1];

	blk_t  cipher;

	// Key registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEY_HIGH: key_high_q <= cfg.data;
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Initial AddRoundKey stage.
	assign blk.ready = !vld_s1 || stg_rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (blk.ready) begin
			vld_s1 <= blk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (blk.valid && blk.ready) begin
			state_s1 <= {blk.block_high, blk.block_low} ^ {key_high_q, key_low_q};
			rkey_s1  <= {key_high_q, key_low_q};
		end
	end

	assign stg_vld[0]   = vld_s1;
	assign stg_state[0] = state_s1;
	assign stg_key[0]   = rkey_s1;

	// Round stages.
	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		aes_round #(
			.Round (r)
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_vld[r-1]),
			.up_ready (stg_rdy[r]),
			.up_state (stg_state[r-1]),
			.up_key   (stg_key[r-1]),
			.dn_valid (stg_vld[r]),
			.dn_ready (stg_rdy[r+1]),
			.dn_state (stg_state[r]),
			.dn_key   (stg_key[r])
		);
	end

	// Output buffer toward the ciphertext channel.
	aes_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (stg_vld[NumRounds]),
		.up_ready (stg_rdy[NumRounds+1]),
		.up_data  (stg_state[NumRounds]),
		.dn_valid (ct.valid),
		.dn_ready (ct.ready),
		.dn_data  (cipher)
	);

	assign ct.cipher_high = cipher[BlkW-1:HalfW];
	assign ct.cipher_low  = cipher[HalfW-1:0];

endmodule

>>> rtl/core/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered pipeline stage: a cipher round plus the matching key schedule
// step, so the round key travels down the pipeline next to its block.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; #(
	parameter int unsigned Round = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  blk_t up_state,
	input  blk_t up_key,
	output logic dn_valid,
	input  logic dn_ready,
	output blk_t dn_state,
	output blk_t dn_key
);

	logic vld_s;
	blk_t state_s;
	blk_t rkey_s;
	blk_t rkey;
	blk_t subsh;
	blk_t mixed;

	// Round key for this round and the round body; the last round skips MixColumns.
	always_comb begin
		rkey  = key_step(up_key, RCON[Round]);
		subsh = sub_shift(up_state);
		mixed = (Round == NumRounds) ? subsh : mix_columns(subsh);
	end

	// The stage takes a new transaction when empty or when its content moves on.
	assign up_ready = !vld_s || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (up_ready) begin
			vld_s <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			state_s <= mixed ^ rkey;
			rkey_s  <= rkey;
		end
	end

	assign dn_valid = vld_s;
	assign dn_state = state_s;
	assign dn_key   = rkey_s;

endmodule

>>> rtl/core/aes_skid.sv
// ----------------------------------------------------------------------------
// AES output skid buffer
// Two-entry output register that cuts the ready path from the ciphertext
// channel back into the round pipeline.
// ----------------------------------------------------------------------------
module aes_skid import aes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  blk_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output blk_t dn_data
);

	logic out_vld_q;
	logic spr_vld_q;
	blk_t out_q;
	blk_t spr_q;
	logic up_fire;
	logic out_free;

	assign up_ready = !spr_vld_q;
	assign up_fire  = up_valid && up_ready;
	assign out_free = dn_ready || !out_vld_q;

	// Valid bits: the spare entry fills only while the output entry is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			spr_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= spr_vld_q || up_fire;
			spr_vld_q <= 1'b0;
		end else if (up_fire) begin
			spr_vld_q <= 1'b1;
		end
	end

	// Payload moves from the spare entry first so order is kept.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= spr_vld_q ? spr_q : up_data;
		end else if (up_fire) begin
			spr_q <= up_data;
		end
	end

	assign dn_valid = out_vld_q;
	assign dn_data  = out_q;

endmodule

>>> rtl/core/aes_chk.sv
// ----------------------------------------------------------------------------
// AES-128 port checker
// Concurrent assertions on the ports of the block, bound to the top level.
// ----------------------------------------------------------------------------
module aes_chk import aes_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input half_t out_high,
	input half_t out_low
);

	// Pipeline stages plus the two output buffer entries.
	localparam int unsigned MaxInFlight = NumRounds + 3;
	localparam int unsigned CntW        = $clog2(MaxInFlight + 1);

	logic [CntW-1:0] cnt_q;
	logic            in_fire;
	logic            out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Blocks accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CntW'(in_fire) - CntW'(out_fire);
		end
	end

	// A stalled ciphertext stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
		else $error("ciphertext changed while stalled");

	// The pipeline never holds more blocks than its stages and output buffer entries.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxInFlight))
		else $error("more blocks in flight than pipeline capacity");

	// No ciphertext appears without a plaintext block behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("ciphertext offered with no block in flight");

	// A full pipeline refuses new blocks.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CntW'(MaxInFlight) |-> !in_ready)
		else $error("input ready while pipeline is full");

endmodule

bind aes128_block_encrypt aes_chk u_aes_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (blk.valid),
	.in_ready  (blk.ready),
	.out_valid (ct.valid),
	.out_ready (ct.ready),
	.out_high  (ct.cipher_high),
	.out_low   (ct.cipher_low)
);

>>> tb/sv/aes128_block_encrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Streams plaintext blocks through the encryption pipeline under a series of
// keys. Every accepted block is encrypted by an independent FIPS-197 model in
// the testbench, and each ciphertext transaction is checked in order against
// it. The sender runs in bursts and the receiver stalls, including long
// hold-offs that back the pipeline up into its input.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_tb import aes_pkg::*;;

	localparam int unsigned RESET_CYCLES      = 7;
	localparam int unsigned DRAIN_CYCLES      = 16;
	localparam int unsigned LONG_STALL_CYCLES = 120;
	localparam int unsigned RANDOM_PHASES     = 5;
	localparam int unsigned HALF_PHASE_BLOCKS = 40;
	localparam int unsigned TIMEOUT_NS        = 2_000_000;
	localparam byte_t       GF_REDUCE         = 8'h1B;
	localparam byte_t       AFFINE_CONST      = 8'h63;
	localparam blk_t        FIPS_KEY          = 128'h000102030405060708090a0b0c0d0e0f;
	localparam blk_t        FIPS_PLAIN        = 128'h00112233445566778899aabbccddeeff;
	localparam blk_t        FIPS_CIPHER       = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;

	typedef struct packed {
		half_t high;
		half_t low;
	} plain_block_t;

	typedef enum int unsigned {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_HOLD
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	aes_cfg_if cfg();
	aes_blk_if blk();
	aes_ct_if  ct();

	aes128_block_encrypt DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.blk    (blk),
		.ct     (ct)
	);

	// Substitution table, derived from the GF(2^8) inverse and the affine map.
	byte_t sub_tab [256];

	// Key as the block should currently hold it.
	half_t key_high_model;
	half_t key_low_model;

	plain_block_t plain_pending [$];
	blk_t         cipher_expected [$];
	blk_t         next_cipher;

	int unsigned errors;
	int unsigned blocks_checked;
	int unsigned key_settings;
	int unsigned stall_requests;
	int unsigned stall_served;

	// Sender burst control.
	int unsigned burst_left;
	int unsigned gap_left;
	plain_block_t send_item;

	// Receiver stall control.
	ready_mode_t ready_mode;
	int unsigned pattern_left;
	int unsigned stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Multiply two elements of GF(2^8).
	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = '0;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				acc ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
		end
		return acc;
	endfunction

	// Full AES-128 encryption of one block; byte 0 is the top byte.
	function automatic blk_t aes_encrypt(input blk_t key, input blk_t plain);
		byte_t st [16];
		byte_t tmp [16];
		word_t rk [44];
		word_t t;
		byte_t rcon;
		byte_t a0, a1, a2, a3;
		blk_t  out;
		for (int i = 0; i < 4; i++)
			rk[i] = key[127-32*i -: 32];
		rcon = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = rk[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]}
					^ {rcon, 24'h000000};
				rcon = gf_mul(rcon, 8'h02);
			end
			rk[i] = rk[i-4] ^ t;
		end
		for (int i = 0; i < 16; i++)
			st[i] = plain[127-8*i -: 8];
		for (int rnd = 0; rnd <= 10; rnd++) begin
			if (rnd > 0) begin
				// SubBytes and ShiftRows: row r rotates left by r columns.
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						tmp[r+4*c] = sub_tab[st[r + 4*((c + r) % 4)]];
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[4*c];
					a1 = tmp[4*c+1];
					a2 = tmp[4*c+2];
					a3 = tmp[4*c+3];
					if (rnd < 10) begin
						st[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
						st[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
						st[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
						st[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
					end else begin
						st[4*c]   = a0;
						st[4*c+1] = a1;
						st[4*c+2] = a2;
						st[4*c+3] = a3;
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					st[r+4*c] ^= rk[4*rnd+c][31-8*r -: 8];
		end
		for (int i = 0; i < 16; i++)
			out[127-8*i -: 8] = st[i];
		return out;
	endfunction

	// Random half block, biased toward all-zero, all-one, one-hot and one-cold values.
	function automatic half_t rand_half();
		half_t one_hot;
		one_hot = half_t'(1) << $urandom_range(0, HalfW - 1);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_block(input half_t high, input half_t low);
		plain_block_t item;
		item.high = high;
		item.low = low;
		plain_pending.push_back(item);
	endtask

	task automatic queue_random_blocks(input int unsigned count);
		for (int unsigned n = 0; n < count; n++)
			queue_block(rand_half(), rand_half());
	endtask

	// Wait until every block is sent and every ciphertext has arrived.
	// The check runs at the falling edge, once the sender's updates have settled.
	task automatic wait_idle();
		while (plain_pending.size() != 0 || blk.valid || cipher_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One configuration transaction; the model key follows at the handshake.
	task automatic write_reg(input cfg_idx_t index, input half_t value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (index)
			REG_KEY_HIGH: key_high_model = value;
			REG_KEY_LOW:  key_low_model = value;
			default: ;
		endcase
		cfg.valid <= 1'b0;
	endtask

	task automatic write_key(input half_t high, input half_t low);
		write_reg(REG_KEY_HIGH, high);
		write_reg(REG_KEY_LOW, low);
		key_settings++;
	endtask

	// Sender: offers queued blocks in bursts and records each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk.valid <= 1'b0;
			blk.block_high <= '0;
			blk.block_low <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (blk.valid && blk.ready)
				cipher_expected.push_back(aes_encrypt({key_high_model, key_low_model},
					{blk.block_high, blk.block_low}));
			if (!blk.valid || blk.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					blk.valid <= 1'b0;
				end else if (plain_pending.size() > 0) begin
					send_item = plain_pending.pop_front();
					blk.valid <= 1'b1;
					blk.block_high <= send_item.high;
					blk.block_low <= send_item.low;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					// A gap of zero joins two bursts into one unbroken stretch.
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 :
							(($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
							$urandom_range(1, 4));
				end else begin
					blk.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each ciphertext transaction and drives its stall pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct.ready <= 1'b0;
			ready_mode = READY_ALWAYS;
			pattern_left = 0;
			stall_left = 0;
		end else begin
			if (ct.valid && ct.ready) begin
				if (cipher_expected.size() == 0) begin
					$error("ciphertext transaction with no block outstanding: %h %h",
						ct.cipher_high, ct.cipher_low);
					errors++;
				end else begin
					next_cipher = cipher_expected.pop_front();
					blocks_checked++;
					if (ct.cipher_high !== next_cipher[127:64]) begin
						$error("cipher_high mismatch: expected %h, actual %h",
							next_cipher[127:64], ct.cipher_high);
						errors++;
					end
					if (ct.cipher_low !== next_cipher[63:0]) begin
						$error("cipher_low mismatch: expected %h, actual %h",
							next_cipher[63:0], ct.cipher_low);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				ct.ready <= 1'b0;
			end else if (stall_served != stall_requests) begin
				// Long hold-off so the pipeline fills and stalls its input.
				stall_served++;
				stall_left = LONG_STALL_CYCLES - 1;
				ct.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					ready_mode = ready_mode_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(8, 48);
				end
				pattern_left--;
				case (ready_mode)
					READY_ALWAYS: ct.ready <= 1'b1;
					READY_COIN:   ct.ready <= 1'($urandom_range(0, 1));
					READY_SPARSE: ct.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						stall_left = $urandom_range(10, 40);
						pattern_left = 0;
						ct.ready <= 1'b0;
					end
				endcase
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		byte_t inv;
		byte_t sq;
		byte_t v;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY_HIGH;
		cfg.data = '0;
		blk.valid = 1'b0;
		blk.block_high = '0;
		blk.block_low = '0;
		ct.ready = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		blocks_checked = 0;
		key_settings = 1;
		stall_requests = 0;
		stall_served = 0;
		key_high_model = '0;
		key_low_model = '0;

		// S-box: multiplicative inverse (a^254) followed by the affine map.
		for (int a = 0; a < 256; a++) begin
			v = byte_t'(a);
			inv = 8'h01;
			sq = v;
			for (int k = 0; k < 8; k++) begin
				if (k > 0)
					inv = gf_mul(inv, sq);
				sq = gf_mul(sq, sq);
			end
			sub_tab[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
		end
		if (aes_encrypt(FIPS_KEY, FIPS_PLAIN) !== FIPS_CIPHER) begin
			$error("model disagrees with the FIPS-197 example vector");
			errors++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Blocks before any key write run under the all-zero key.
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h8000000000000000, 64'h0000000000000001);
		queue_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		queue_block(FIPS_PLAIN[127:64], FIPS_PLAIN[63:0]);
		wait_idle();

		write_key(FIPS_KEY[127:64], FIPS_KEY[63:0]);
		queue_block(FIPS_PLAIN[127:64], FIPS_PLAIN[63:0]);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h0000000000000001, 64'h8000000000000000);
		wait_idle();

		write_key('1, '1);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(FIPS_PLAIN[127:64], FIPS_PLAIN[63:0]);
		wait_idle();

		// Changing only the low key half must affect the very next block.
		write_reg(REG_KEY_LOW, '0);
		key_settings++;
		queue_block('1, '1);
		queue_block(FIPS_PLAIN[127:64], FIPS_PLAIN[63:0]);
		queue_block('0, '0);
		wait_idle();

		// Random blocks under a sequence of keys, extremes included.
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: write_key('0, '0);
				3: write_key('1, {$urandom, $urandom});
				default: write_key({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			if (phase == 1 || phase == 3)
				stall_requests++;
			queue_random_blocks(HALF_PHASE_BLOCKS);
			// Sender pause until every outstanding ciphertext has come back.
			if (phase == 2)
				wait_idle();
			queue_random_blocks(HALF_PHASE_BLOCKS);
			wait_idle();
		end

		$display("Run covered %0d blocks checked under %0d key settings,",
			blocks_checked, key_settings);
		$display("with burst traffic, random output stalls and %0d long hold-offs.",
			stall_served);
		if (errors == 0) begin
			$display("** aes128_block_encrypt: PASSED **");
		end else begin
			$display("** aes128_block_encrypt: FAILED **");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d ciphertexts outstanding.", cipher_expected.size());
		$display("** aes128_block_encrypt: FAILED **");
		$finish;
	end

endmodule
